### design/ppmhp_pkg.sv
// Package for the streaming netpbm header parser and sample unpacker.
// Holds payload structs, parse phase and status codes, character codes and helpers.
// No dependencies; every other design file imports it.
package ppmhp_pkg;

  // Default upper bound on image width and height
  localparam int MAX_DIM_DEFAULT = 4096;

  // Fixed widths of the accumulator, the buffer address, the output dimensions and the max value
  localparam int ACC_W  = 17;
  localparam int ADDR_W = 26;
  localparam int OUT_DIM_W = 13;
  localparam int MAXV_W = 16;

  localparam logic [ACC_W-1:0] ACC_SAT = 17'h10000;

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [3:0] {
    PH_MAGIC_LETTER,
    PH_MAGIC_DIGIT,
    PH_AFTER_MAGIC,
    PH_W_SEEK,
    PH_W_DIGITS,
    PH_H_SEEK,
    PH_H_DIGITS,
    PH_M_SEEK,
    PH_M_DIGITS,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_PIXEL,
    ST_LAST,
    ST_ERROR,
    ST_IGNORED
  } status_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [2:0]           format_digit;
    logic [OUT_DIM_W-1:0] image_width;
    logic [OUT_DIM_W-1:0] image_height;
    logic [MAXV_W-1:0]    max_value;
    logic [7:0]           pixel_value;
    logic [ADDR_W-1:0]    pixel_address;
    logic [1:0]           channel;
  } out_item_t;

  // Space, tab, newline, vertical tab, form feed or carriage return
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

### design/ppmhp_if.sv
// Handshake channels for the parser: one for input bytes, one for results.
// Depends on ppmhp_pkg for the payload structs.
interface ppmhp_in_if;
  import ppmhp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppmhp_out_if;
  import ppmhp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/ppm_header_parse_and_unpack.sv
// A byte's result is registered in the output register, or in the skid register while
// the output is held. Throughput: one byte per cycle while the skid register is empty;
// the two-entry result buffer (output plus skid) lets a byte enter while a result waits.
// Reset (rst_n low, synchronous) clears the parser to wait for the magic letter and
// empties the result buffer; a byte with restart set resets the parser state first.
module ppm_header_parse_and_unpack #(
  parameter int MAX_DIM = ppmhp_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  ppmhp_in_if.sink    in_ch,
  ppmhp_out_if.source out_ch
);
  import ppmhp_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = DIM_W + 1;
  localparam int W3_W  = DIM_W + 2;

  // Parser state
  phase_t             phase_r, phase_nxt, cur_phase;
  logic [ACC_W-1:0]   acc_r, acc_nxt, cur_acc;
  logic               comment_r, comment_nxt, cur_comment;
  logic [2:0]         magic_r, magic_nxt, cur_magic;
  logic [DIM_W-1:0]   width_r, width_nxt, cur_width;
  logic [DIM_W-1:0]   height_r, height_nxt, cur_height;
  logic [MAXV_W-1:0]  maxval_r, maxval_nxt, cur_maxval;
  logic [W3_W-1:0]    w3_r, w3_nxt, cur_w3;
  logic [DIM_W-1:0]   col_r, col_nxt, cur_col;
  logic [DIM_W-1:0]   row_r, row_nxt, cur_row;
  logic [1:0]         chan_r, chan_nxt, cur_chan;
  logic [ADDR_W-1:0]  addr_r, addr_nxt, cur_addr;
  logic [ADDR_W-1:0]  base_r;
  logic [DIM_W-1:0]   height_m1;

  // Result buffer
  out_item_t out_r, skid_r, res;
  logic      out_v_r, skid_v_r;
  logic      in_fire, out_fire;

  // Datapath helpers
  logic [7:0]        b;
  logic              restart;
  logic [3:0]        dval;
  logic [19:0]       acc_mul;
  logic [ACC_W-1:0]  acc_step;
  logic              num_ends;
  logic              dim_bad;
  logic              last_px;
  logic [ADDR_W-1:0] six_w;
  logic [15:0]       width16, height16;

  assign b       = in_ch.data.in_byte;
  assign restart = in_ch.data.restart;

  assign in_ch.ready  = !skid_v_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;
  assign out_fire     = out_v_r && out_ch.ready;

  // Start from reset values when this byte opens a new file
  always_comb begin
    cur_phase   = restart ? PH_MAGIC_LETTER : phase_r;
    cur_acc     = restart ? '0 : acc_r;
    cur_comment = restart ? 1'b0 : comment_r;
    cur_magic   = restart ? '0 : magic_r;
    cur_width   = restart ? '0 : width_r;
    cur_height  = restart ? '0 : height_r;
    cur_maxval  = restart ? '0 : maxval_r;
    cur_w3      = restart ? '0 : w3_r;
    cur_col     = restart ? '0 : col_r;
    cur_row     = restart ? '0 : row_r;
    cur_chan    = restart ? '0 : chan_r;
    cur_addr    = restart ? '0 : addr_r;
  end

  // Decimal accumulate, saturating at 65536
  assign dval    = 4'(b - CH_ZERO);
  assign acc_mul = (20'(cur_acc) << 3) + (20'(cur_acc) << 1) + 20'(dval);
  assign acc_step = (cur_acc[ACC_W-1] || (acc_mul > 20'(ACC_SAT))) ? ACC_SAT
                                                                   : ACC_W'(acc_mul);
  assign num_ends = (cur_phase == PH_M_DIGITS) ? ((b == CH_NL) || (b == CH_HASH))
                                               : (is_blank(b) || (b == CH_HASH));
  assign dim_bad  = (cur_acc == '0) || (cur_acc > ACC_W'(MAX_DIM));

  assign six_w   = ADDR_W'(cur_w3) << 1;
  assign last_px = (CNT_W'(cur_row) + 1'b1 >= CNT_W'(cur_height)) &&
                   (CNT_W'(cur_col) + 1'b1 >= CNT_W'(cur_width)) &&
                   (cur_chan >= 2'd2);

  // Next parser state and the result of this byte
  always_comb begin
    phase_nxt   = cur_phase;
    acc_nxt     = cur_acc;
    comment_nxt = cur_comment;
    magic_nxt   = cur_magic;
    width_nxt   = cur_width;
    height_nxt  = cur_height;
    maxval_nxt  = cur_maxval;
    w3_nxt      = cur_w3;
    col_nxt     = cur_col;
    row_nxt     = cur_row;
    chan_nxt    = cur_chan;
    addr_nxt    = cur_addr;
    res         = '0;
    res.status  = ST_HEADER;

    if (cur_phase == PH_ERROR) begin
      res.status = ST_ERROR;
    end else if (cur_phase == PH_DONE) begin
      res.status = ST_IGNORED;
    end else if (cur_comment) begin
      if (b == CH_NL) comment_nxt = 1'b0;
    end else if (cur_phase == PH_PIXELS) begin
      res.pixel_value   = b;
      res.pixel_address = cur_addr;
      res.channel       = cur_chan;
      if (last_px) begin
        res.status = ST_LAST;
        phase_nxt  = PH_DONE;
      end else begin
        res.status = ST_PIXEL;
        addr_nxt   = cur_addr + 1'b1;
        chan_nxt   = cur_chan + 1'b1;
        // Wrap the channel, then the column; step back two rows' worth at a row end
        if (cur_chan == 2'd2) begin
          chan_nxt = '0;
          col_nxt  = cur_col + 1'b1;
          if (CNT_W'(cur_col) + 1'b1 >= CNT_W'(cur_width)) begin
            col_nxt  = '0;
            row_nxt  = cur_row + 1'b1;
            addr_nxt = cur_addr + 1'b1 - six_w;
          end
        end
      end
    end else begin
      unique case (cur_phase)
        PH_MAGIC_LETTER: begin
          if (b == CH_HASH) comment_nxt = 1'b1;
          else if ((b == CH_UP_P) || (b == CH_LO_P)) phase_nxt = PH_MAGIC_DIGIT;
          else if (!(is_blank(b) && (b != CH_NL))) phase_nxt = PH_ERROR;
        end
        PH_MAGIC_DIGIT: begin
          if ((b >= CH_ONE) && (b <= CH_SIX)) begin
            magic_nxt = 3'(b - CH_ZERO);
            phase_nxt = PH_AFTER_MAGIC;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_AFTER_MAGIC: begin
          if (b == CH_HASH) begin
            comment_nxt = 1'b1;
            phase_nxt   = PH_W_SEEK;
          end else if (is_blank(b)) begin
            phase_nxt = PH_W_SEEK;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_W_SEEK, PH_H_SEEK, PH_M_SEEK: begin
          if (b == CH_HASH) begin
            comment_nxt = 1'b1;
          end else if (is_digit(b)) begin
            acc_nxt   = ACC_W'(dval);
            phase_nxt = (cur_phase == PH_W_SEEK) ? PH_W_DIGITS :
                        (cur_phase == PH_H_SEEK) ? PH_H_DIGITS : PH_M_DIGITS;
          end else if (!is_blank(b)) begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_W_DIGITS, PH_H_DIGITS, PH_M_DIGITS: begin
          if (is_digit(b)) begin
            acc_nxt = acc_step;
          end else if (!num_ends) begin
            phase_nxt = PH_ERROR;
          end else begin
            // Commit the number to its field
            acc_nxt = '0;
            if (cur_phase == PH_W_DIGITS) begin
              if (dim_bad) begin
                phase_nxt = PH_ERROR;
              end else begin
                width_nxt = DIM_W'(cur_acc);
                w3_nxt    = W3_W'(cur_acc) + (W3_W'(cur_acc) << 1);
                phase_nxt = PH_H_SEEK;
              end
            end else if (cur_phase == PH_H_DIGITS) begin
              if (dim_bad) begin
                phase_nxt = PH_ERROR;
              end else begin
                height_nxt = DIM_W'(cur_acc);
                phase_nxt  = PH_M_SEEK;
              end
            end else begin
              if (cur_acc[ACC_W-1]) begin
                phase_nxt = PH_ERROR;
              end else begin
                maxval_nxt = MAXV_W'(cur_acc);
                addr_nxt   = base_r;
                col_nxt    = '0;
                row_nxt    = '0;
                chan_nxt   = '0;
                phase_nxt  = PH_PIXELS;
              end
            end
            if ((b == CH_HASH) && (phase_nxt != PH_ERROR)) comment_nxt = 1'b1;
          end
        end
        default: ;
      endcase
      if (phase_nxt == PH_ERROR) res.status = ST_ERROR;
    end

    width16  = 16'(width_nxt);
    height16 = 16'(height_nxt);
    res.format_digit = magic_nxt;
    res.image_width  = width16[OUT_DIM_W-1:0];
    res.image_height = height16[OUT_DIM_W-1:0];
    res.max_value    = maxval_nxt;
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC_LETTER;
      acc_r     <= '0;
      comment_r <= 1'b0;
      magic_r   <= '0;
      width_r   <= '0;
      height_r  <= '0;
      maxval_r  <= '0;
      w3_r      <= '0;
      col_r     <= '0;
      row_r     <= '0;
      chan_r    <= '0;
      addr_r    <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      comment_r <= comment_nxt;
      magic_r   <= magic_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      maxval_r  <= maxval_nxt;
      w3_r      <= w3_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      chan_r    <= chan_nxt;
      addr_r    <= addr_nxt;
    end
  end

  // Top row base, (h-1)*w*3; settles long before maxval can end
  assign height_m1 = height_r - 1'b1;
  always_ff @(posedge clk) begin
    base_r <= ADDR_W'(ADDR_W'(height_m1) * ADDR_W'(w3_r));
  end

  // Result buffer: output register backed by one skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_fire || !out_v_r) begin
      out_v_r  <= skid_v_r || in_fire;
      skid_v_r <= 1'b0;
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_v_r) begin
      if (skid_v_r) out_r <= skid_r;
      else          out_r <= res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  // Skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry without an output entry");

  // A transfer into an empty buffer always yields a result next cycle
  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_v_r) |=> out_v_r)
    else $error("result lost after transfer");

  // Sticky error once the parser has failed
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !restart && (phase_r == PH_ERROR)) |-> (res.status == ST_ERROR))
    else $error("error state not reported");

  // Samples only come out of the pixel phase
  a_pixel_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ((res.status == ST_PIXEL) || (res.status == ST_LAST)))
      |-> (cur_phase == PH_PIXELS))
    else $error("sample reported outside pixel phase");

  // Channel counter never reaches three
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r != 2'd3)
    else $error("channel counter out of range");

endmodule
